@@ hdl/scl_pkg.sv @@
package scl_pkg;

  localparam int LINE_LIMIT = 128;
  localparam int LEN_W      = $clog2(LINE_LIMIT);
  localparam int TOK_W      = 7;
  localparam int NAME_COUNT = 5;
  localparam int CMD_W      = 3;
  localparam int POS_W      = 3;
  localparam int CNT_W      = 6;
  localparam int VAL_W      = 32;

  localparam logic [TOK_W-1:0] TOK_MAX   = '1;
  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [4:0]       ALL_NAMES = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [CMD_W-1:0] {
    CMD_HELP  = 3'd0,
    CMD_HELLO = 3'd1,
    CMD_MEAS  = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_START = 3'd4
  } cmd_t;

  // number parser phase: leading blanks, after sign, in digits, finished
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_END
  } phase_t;

  typedef struct packed {
    logic   ovf;
    logic   neg;
    phase_t phase;
  } num_flags_t;

  typedef struct packed {
    logic [VAL_W-1:0] acc;
    num_flags_t       flags;
  } num_state_t;

  function automatic logic [2:0] cmd_len(input logic [CMD_W-1:0] idx);
    logic [2:0] len;
    case (idx)
      CMD_HELP:  len = 3'd4;
      CMD_HELLO: len = 3'd5;
      CMD_MEAS:  len = 3'd4;
      CMD_STOP:  len = 3'd4;
      CMD_START: len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [CMD_W-1:0] idx,
                                          input logic [POS_W-1:0] pos);
    logic [63:0] name;
    logic [63:0] shifted;
    case (idx)
      CMD_HELP:  name = {"Help",  32'h0};
      CMD_HELLO: name = {"Hello", 24'h0};
      CMD_MEAS:  name = {"Meas",  32'h0};
      CMD_STOP:  name = {"Stop",  32'h0};
      CMD_START: name = {"Start", 24'h0};
      default:   name = '0;
    endcase
    shifted = name << {pos, 3'b000};
    return shifted[63:56];
  endfunction

  // one character of a strtoul-style decimal parse; x10 as two shifts and an add
  function automatic num_state_t num_step(input num_state_t s, input logic [7:0] c);
    num_state_t r;
    logic [VAL_W+3:0] prod;
    logic digit;
    r = s;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {28'b0, c - CH_ZERO};
    if (s.flags.phase == PH_LEAD && (c == CH_TAB || c == CH_VT || c == CH_FF)) begin
      r = s;
    end else if (s.flags.phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
      r.flags.phase = PH_SIGN;
      if (c == CH_MINUS) begin
        r.flags.neg = 1'b1;
      end
    end else if (s.flags.phase != PH_END && digit) begin
      if (prod[VAL_W+3:VAL_W] != 4'b0) begin
        r.flags.ovf = 1'b1;
        r.acc = '1;
      end else begin
        r.acc = prod[VAL_W-1:0];
      end
      r.flags.phase = PH_DIGITS;
    end else begin
      r.flags.phase = PH_END;
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] num_value(input num_state_t s);
    logic [VAL_W-1:0] v;
    if (s.flags.ovf) begin
      v = '1;
    end else if (s.flags.neg) begin
      v = '0 - s.acc;
    end else begin
      v = s.acc;
    end
    return v;
  endfunction

endpackage

@@ hdl/serial_command_line_parser.sv @@
// Latency: a result appears on out_* in the cycle after the CR/LF beat that ends its line.
// Throughput: one byte per cycle while in_ready is high; each beat is folded into the line state in the
// accept cycle, and in_ready is high while the single output register is empty or out_ready is high.
// Reset (rst_n low at a clock edge, synchronous): line state cleared, every command
// name a candidate again, held parameter values zero, no result pending.
module serial_command_line_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scl_pkg::CMD_W-1:0]    out_command_index,
  output logic [scl_pkg::CNT_W-1:0]    out_param_count,
  output logic [scl_pkg::VAL_W-1:0]    out_first_value,
  output logic [scl_pkg::VAL_W-1:0]    out_second_value
);

  // line state
  logic [scl_pkg::LEN_W-1:0]      line_len_r, line_len_nxt;
  logic [scl_pkg::TOK_W-1:0]      tok_r, tok_nxt;
  logic                           in_tok_r, in_tok_nxt;
  logic [scl_pkg::NAME_COUNT-1:0] cand_r, cand_nxt;
  logic [scl_pkg::POS_W-1:0]      pos_r, pos_nxt;
  scl_pkg::num_state_t            num0_r, num0_nxt;
  scl_pkg::num_state_t            num1_r, num1_nxt;
  logic [scl_pkg::VAL_W-1:0]      held0_r, held0_nxt;
  logic [scl_pkg::VAL_W-1:0]      held1_r, held1_nxt;

  // result register
  logic                           out_valid_r;
  logic [scl_pkg::CMD_W-1:0]      out_cmd_r, out_cmd_nxt;
  logic [scl_pkg::CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic [scl_pkg::VAL_W-1:0]      out_v0_r;
  logic [scl_pkg::VAL_W-1:0]      out_v1_r;

  logic                           in_fire;
  logic                           is_term;
  logic                           emit;
  logic                           line_full;
  logic                           hit;
  logic [scl_pkg::LEN_W-1:0]      eff_len;
  logic [scl_pkg::TOK_W-1:0]      eff_tok;
  logic                           eff_in_tok;
  logic [scl_pkg::NAME_COUNT-1:0] eff_cand;
  logic [scl_pkg::POS_W-1:0]      eff_pos;
  scl_pkg::num_state_t            eff_num0;
  scl_pkg::num_state_t            eff_num1;
  logic [scl_pkg::TOK_W-1:0]      tok_new;
  logic [scl_pkg::TOK_W-1:0]      params;
  scl_pkg::num_state_t            num_clear;

  // Take a new beat whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_term  = (in_rx_byte == scl_pkg::CH_CR) || (in_rx_byte == scl_pkg::CH_LF);

  assign num_clear = '{acc: '0, flags: '{ovf: 1'b0, neg: 1'b0, phase: scl_pkg::PH_LEAD}};

  // An overlong line restarts before the incoming byte is looked at.
  assign line_full = (line_len_r == scl_pkg::LEN_W'(scl_pkg::LINE_LIMIT - 1));

  always_comb begin
    if (line_full) begin
      eff_len    = '0;
      eff_tok    = '0;
      eff_in_tok = 1'b0;
      eff_cand   = scl_pkg::ALL_NAMES;
      eff_pos    = '0;
      eff_num0   = num_clear;
      eff_num1   = num_clear;
    end else begin
      eff_len    = line_len_r;
      eff_tok    = tok_r;
      eff_in_tok = in_tok_r;
      eff_cand   = cand_r;
      eff_pos    = pos_r;
      eff_num0   = num0_r;
      eff_num1   = num1_r;
    end

    line_len_nxt = eff_len;
    tok_nxt      = eff_tok;
    in_tok_nxt   = eff_in_tok;
    cand_nxt     = eff_cand;
    pos_nxt      = eff_pos;
    num0_nxt     = eff_num0;
    num1_nxt     = eff_num1;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    emit         = 1'b0;
    hit          = 1'b0;
    out_cmd_nxt  = '0;
    out_cnt_nxt  = '0;
    tok_new      = eff_tok;
    params       = eff_tok - scl_pkg::TOK_W'(1);

    if (is_term) begin
      // Pick the first surviving name whose length matches the first token.
      for (int i = 0; i < scl_pkg::NAME_COUNT; i++) begin
        if (!hit && eff_cand[i] &&
            scl_pkg::cmd_len(scl_pkg::CMD_W'(i)) == eff_pos) begin
          hit         = 1'b1;
          out_cmd_nxt = scl_pkg::CMD_W'(i);
        end
      end
      if (eff_len != '0 && eff_tok != '0 && hit) begin
        emit = 1'b1;
        out_cnt_nxt = (params > scl_pkg::TOK_W'(scl_pkg::CNT_MAX)) ?
                      scl_pkg::CNT_MAX : params[scl_pkg::CNT_W-1:0];
        // No parameters: repeat the held values.
        if (eff_tok > scl_pkg::TOK_W'(1)) begin
          held0_nxt = scl_pkg::num_value(eff_num0);
          held1_nxt = (eff_tok >= scl_pkg::TOK_W'(3)) ? scl_pkg::num_value(eff_num1) : '0;
        end
      end
      line_len_nxt = '0;
      tok_nxt      = '0;
      in_tok_nxt   = 1'b0;
      cand_nxt     = scl_pkg::ALL_NAMES;
      pos_nxt      = '0;
      num0_nxt     = num_clear;
      num1_nxt     = num_clear;
    end else begin
      line_len_nxt = eff_len + scl_pkg::LEN_W'(1);
      if (in_rx_byte == scl_pkg::CH_SPACE || in_rx_byte == scl_pkg::CH_NUL) begin
        in_tok_nxt = 1'b0;
      end else begin
        if (!eff_in_tok && eff_tok != scl_pkg::TOK_MAX) begin
          tok_new = eff_tok + scl_pkg::TOK_W'(1);
        end
        in_tok_nxt = 1'b1;
        tok_nxt    = tok_new;
        if (tok_new == scl_pkg::TOK_W'(1)) begin
          // Drop every name that this character rules out.
          for (int i = 0; i < scl_pkg::NAME_COUNT; i++) begin
            if (eff_pos >= scl_pkg::cmd_len(scl_pkg::CMD_W'(i)) ||
                scl_pkg::cmd_char(scl_pkg::CMD_W'(i), eff_pos) != in_rx_byte) begin
              cand_nxt[i] = 1'b0;
            end
          end
          if (eff_pos != scl_pkg::POS_MAX) begin
            pos_nxt = eff_pos + scl_pkg::POS_W'(1);
          end
        end else if (tok_new == scl_pkg::TOK_W'(2)) begin
          num0_nxt = scl_pkg::num_step(eff_num0, in_rx_byte);
        end else if (tok_new == scl_pkg::TOK_W'(3)) begin
          num1_nxt = scl_pkg::num_step(eff_num1, in_rx_byte);
        end
      end
    end
  end

  // Advance the line state on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      tok_r      <= '0;
      in_tok_r   <= 1'b0;
      cand_r     <= scl_pkg::ALL_NAMES;
      pos_r      <= '0;
      num0_r     <= num_clear;
      num1_r     <= num_clear;
      held0_r    <= '0;
      held1_r    <= '0;
    end else if (in_fire) begin
      line_len_r <= line_len_nxt;
      tok_r      <= tok_nxt;
      in_tok_r   <= in_tok_nxt;
      cand_r     <= cand_nxt;
      pos_r      <= pos_nxt;
      num0_r     <= num0_nxt;
      num1_r     <= num1_nxt;
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
    end
  end

  // Result register: load on a terminator that matched, hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_cmd_r <= out_cmd_nxt;
      out_cnt_r <= out_cnt_nxt;
      out_v0_r  <= held0_nxt;
      out_v1_r  <= held1_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command_index = out_cmd_r;
  assign out_param_count   = out_cnt_r;
  assign out_first_value   = out_v0_r;
  assign out_second_value  = out_v1_r;

`ifndef SYNTHESIS
  a_no_result_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_term |=> !out_valid_r)
    else $error("result raised by a byte that does not end a line");

  a_term_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_term |=> line_len_r == '0 && tok_r == '0 && cand_r == scl_pkg::ALL_NAMES)
    else $error("line state not cleared after terminator");

  a_line_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= scl_pkg::LEN_W'(scl_pkg::LINE_LIMIT - 1))
    else $error("line length beyond limit");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cmd_r <= scl_pkg::CMD_START)
    else $error("command index out of range");
`endif

endmodule
